FILE: hw/rtl/flsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_pkg
// shared codes, types and constants of the free list segment allocator
// ----------------------------------------------------------------------------
package flsa_pkg;

  localparam int SIZE_W    = 32;
  localparam int NEED_W    = 33;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_SAT = 32'hFFFF_FFFF;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd2;

  localparam logic [1:0]        FIT_MODE_RESET   = FIT_FIRST;
  localparam logic [SIZE_W-1:0] HEAP_BASE_RESET  = 32'd4096;
  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RESET = 32'd1048576;

  typedef enum logic [1:0] {
    OPC_ALLOC = 2'd0,
    OPC_FREE  = 2'd1,
    OPC_CLEAR = 2'd2,
    OPC_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OOM        = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NULL_FREE  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALIGN,
    S_SCAN_INIT,
    S_SCAN,
    S_DECIDE,
    S_BRK,
    S_SHDN_INIT,
    S_SHDN,
    S_SHUP_INIT,
    S_SHUP,
    S_INSERT,
    S_MRG_RD0,
    S_MRG_CUR,
    S_MRG_NEXT,
    S_MRG_CMP,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ALIGN,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_GRANT,
    OP_BRK,
    OP_SHDN_INIT,
    OP_SHDN,
    OP_SHUP_INIT,
    OP_SHUP,
    OP_INSERT,
    OP_MRG_RD0,
    OP_MRG_CUR,
    OP_MRG_RDJ,
    OP_MRG_CMP,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_clear;
    logic reject;
    logic align_done;
    logic scan_done;
    logic found;
    logic shdn_done;
    logic shup_done;
    logic merge_more;
    logic merge_hit;
  } dp_status_t;

endpackage

FILE: hw/rtl/flsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_dp
// datapath: free table memories, align unit, scan, shift and merge logic
// ----------------------------------------------------------------------------
module flsa_dp #(
  parameter int FREE_SLOTS   = 64,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 16,
  parameter int ADDR_BITS    = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  flsa_pkg::dp_cmd_t                     cmd,
  output flsa_pkg::dp_status_t                  sts,
  input  logic                                  cfg_wr_en,
  input  logic [flsa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [flsa_pkg::SIZE_W-1:0]           cfg_wdata,
  input  logic [1:0]                            opcode,
  input  logic [flsa_pkg::SIZE_W-1:0]           req_size,
  input  logic [flsa_pkg::SIZE_W-1:0]           payload_addr,
  output logic [flsa_pkg::SIZE_W-1:0]           result_addr,
  output logic [flsa_pkg::SIZE_W-1:0]           granted_size,
  output logic [1:0]                            status
);

  localparam int AW = ADDR_BITS;
  localparam int LW = (AW > 32) ? AW : 32;
  localparam int XW = LW + 2;
  localparam int KW = ((LW > 34) ? LW : 34) + 1;
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int RW = $clog2(ALIGN_BYTES) + 1;
  localparam int NW = flsa_pkg::NEED_W;
  localparam int DW = ((NW + 3) / 4) * 4;
  localparam int BW = $clog2(NW + 1);
  localparam int SW = flsa_pkg::SIZE_W;

  logic [AW-1:0] start_mem [FREE_SLOTS];
  logic [SW-1:0] size_mem  [FREE_SLOTS];

  flsa_pkg::opcode_t item_op;
  logic [NW-1:0] sum, need;
  logic [DW-1:0] shreg;
  logic [RW-1:0] rem;
  logic [BW-1:0] bit_cnt;
  logic [AW-1:0] blk;
  logic [SW-1:0] fsize;

  logic [CW-1:0] ptr, pick, base_i, count;
  logic          pend, found;
  logic [IW-1:0] pend_ptr;
  logic [AW-1:0] rd_start, pick_start, cur_start;
  logic [SW-1:0] rd_size, pick_size, cur_size;

  logic [AW-1:0] brk;
  logic [1:0]    fit_mode;
  logic [SW-1:0] heap_limit;

  logic [SW-1:0] res_addr, res_size;
  logic [1:0]    res_status;

  // memory port controls
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_ra, mem_wa;
  logic [AW-1:0] wd_start;
  logic [SW-1:0] wd_size;

  logic          stop_first, scan_issue, shdn_issue, shup_issue;
  logic          is_best, is_worst, take_alloc, take_free, merge_hit;
  logic [CW-1:0] ptr_m1, base_p1, pick_p1;
  logic [CW:0]   base_p1_x;
  logic [RW+3:0] rem_t, rem_8, rem_4, rem_2;
  logic [RW-1:0] rem_step;
  logic [XW-1:0] cur_end;
  logic [33:0]   merge_sum;
  logic [SW-1:0] merged;
  logic [LW-1:0] limit_x, mask_x, lim, brk_hdr, pay_x;
  logic [KW-1:0] brk_k, lim_k, total_k;
  logic          oom;
  logic [AW-1:0] grant_addr;
  logic [1:0]    load_status;

  always_comb begin
    is_best    = (fit_mode == flsa_pkg::FIT_BEST);
    is_worst   = (fit_mode == flsa_pkg::FIT_WORST);
    stop_first = (item_op == flsa_pkg::OPC_FREE) || !(is_best || is_worst);
    scan_issue = (ptr < count) && !(found && stop_first);
    shdn_issue = (ptr < count);
    ptr_m1     = ptr - CW'(1);
    shup_issue = (ptr > pick);
    base_p1    = base_i + CW'(1);
    base_p1_x  = (CW+1)'(base_i) + (CW+1)'(1);
    pick_p1    = pick + CW'(1);

    take_alloc = pend && ({1'b0, rd_size} >= need) &&
                 (!found || (is_best && rd_size < pick_size) ||
                  (is_worst && rd_size > pick_size));
    take_free  = pend && !found && (rd_start >= blk);

    // align remainder, one nibble a cycle, reduced by 8, 4, 2 and 1 times the alignment
    rem_t    = {rem, shreg[DW-1 -: 4]};
    rem_8    = (rem_t >= (RW+4)'(8 * ALIGN_BYTES)) ? rem_t - (RW+4)'(8 * ALIGN_BYTES)
                                                   : rem_t;
    rem_4    = (rem_8 >= (RW+4)'(4 * ALIGN_BYTES)) ? rem_8 - (RW+4)'(4 * ALIGN_BYTES)
                                                   : rem_8;
    rem_2    = (rem_4 >= (RW+4)'(2 * ALIGN_BYTES)) ? rem_4 - (RW+4)'(2 * ALIGN_BYTES)
                                                   : rem_4;
    rem_step = (rem_2 >= (RW+4)'(ALIGN_BYTES)) ? RW'(rem_2 - (RW+4)'(ALIGN_BYTES))
                                               : RW'(rem_2);

    cur_end   = XW'(cur_start) + XW'(HEADER_BYTES) + XW'(cur_size);
    merge_hit = (cur_end == XW'(rd_start));
    merge_sum = 34'(cur_size) + 34'(HEADER_BYTES) + 34'(rd_size);
    merged    = (merge_sum[33:32] != 2'b00) ? flsa_pkg::SIZE_SAT : merge_sum[31:0];

    limit_x = LW'(heap_limit);
    mask_x  = LW'({AW{1'b1}});
    lim     = (limit_x < mask_x) ? limit_x : mask_x;
    brk_k   = KW'(brk);
    lim_k   = KW'(lim);
    total_k = KW'(need) + KW'(HEADER_BYTES);
    oom     = (brk_k > lim_k) || (total_k > lim_k - brk_k);
    brk_hdr = LW'(brk) + LW'(HEADER_BYTES);

    grant_addr = pick_start + AW'(HEADER_BYTES);
    pay_x      = LW'(payload_addr) - LW'(HEADER_BYTES);

    if (opcode == flsa_pkg::OPC_FREE && payload_addr == '0) begin
      load_status = flsa_pkg::ST_NULL_FREE;
    end else if (opcode == flsa_pkg::OPC_FREE && count >= CW'(FREE_SLOTS)) begin
      load_status = flsa_pkg::ST_TABLE_FULL;
    end else begin
      load_status = flsa_pkg::ST_OK;
    end
  end

  // memory address and write data selection
  always_comb begin
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    mem_ra   = ptr[IW-1:0];
    mem_wa   = pend_ptr;
    wd_start = rd_start;
    wd_size  = rd_size;
    unique case (cmd.op)
      flsa_pkg::OP_SCAN: begin
        mem_re = scan_issue;
      end
      flsa_pkg::OP_SHDN: begin
        mem_re = shdn_issue;
        mem_we = pend;
        mem_wa = pend_ptr - IW'(1);
      end
      flsa_pkg::OP_SHUP: begin
        mem_ra = ptr_m1[IW-1:0];
        mem_re = shup_issue;
        mem_we = pend;
        mem_wa = pend_ptr + IW'(1);
      end
      flsa_pkg::OP_INSERT: begin
        mem_we   = 1'b1;
        mem_wa   = pick[IW-1:0];
        wd_start = blk;
        wd_size  = fsize;
      end
      flsa_pkg::OP_MRG_RD0: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      flsa_pkg::OP_MRG_RDJ: begin
        mem_re = 1'b1;
        mem_ra = base_p1[IW-1:0];
      end
      flsa_pkg::OP_MRG_CMP: begin
        mem_we   = merge_hit;
        mem_wa   = base_i[IW-1:0];
        wd_start = cur_start;
        wd_size  = merged;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_mem[mem_wa] <= wd_start;
      size_mem[mem_wa]  <= wd_size;
    end
    if (mem_re) begin
      rd_start <= start_mem[mem_ra];
      rd_size  <= size_mem[mem_ra];
    end
  end

  // control registers: table fill, break pointer, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend       <= 1'b0;
      brk        <= AW'(flsa_pkg::HEAP_BASE_RESET);
      fit_mode   <= flsa_pkg::FIT_MODE_RESET;
      heap_limit <= flsa_pkg::HEAP_LIMIT_RESET;
    end else begin
      unique case (cmd.op)
        flsa_pkg::OP_SCAN: pend <= scan_issue;
        flsa_pkg::OP_SHDN: pend <= shdn_issue;
        flsa_pkg::OP_SHUP: pend <= shup_issue;
        default:           pend <= 1'b0;
      endcase
      unique case (cmd.op)
        flsa_pkg::OP_SHDN: begin
          if (!pend && !shdn_issue) begin
            count <= count - CW'(1);
          end
        end
        flsa_pkg::OP_INSERT: count <= count + CW'(1);
        flsa_pkg::OP_CLEAR:  count <= '0;
        flsa_pkg::OP_BRK: begin
          if (!oom) begin
            brk <= AW'(brk_k + total_k);
          end
        end
        default: begin
        end
      endcase
      if (cfg_wr_en) begin
        unique case (cfg_index)
          flsa_pkg::CFG_FIT_MODE:   fit_mode <= cfg_wdata[1:0];
          flsa_pkg::CFG_HEAP_BASE:  brk <= AW'(cfg_wdata);
          flsa_pkg::CFG_HEAP_LIMIT: heap_limit <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pend_ptr <= mem_ra;
    unique case (cmd.op)
      flsa_pkg::OP_LOAD: begin
        item_op    <= flsa_pkg::opcode_t'(opcode);
        sum        <= NW'(req_size) + NW'(ALIGN_BYTES - 1);
        shreg      <= DW'(req_size) + DW'(ALIGN_BYTES - 1);
        rem        <= '0;
        bit_cnt    <= '0;
        blk        <= AW'(pay_x);
        fsize      <= req_size;
        res_addr   <= '0;
        res_size   <= '0;
        res_status <= load_status;
      end
      flsa_pkg::OP_ALIGN: begin
        shreg   <= {shreg[DW-5:0], 4'b0000};
        rem     <= rem_step;
        bit_cnt <= bit_cnt + BW'(1);
      end
      flsa_pkg::OP_SCAN_INIT: begin
        need  <= sum - NW'(rem);
        ptr   <= '0;
        found <= 1'b0;
      end
      flsa_pkg::OP_SCAN: begin
        if (scan_issue) begin
          ptr <= ptr + CW'(1);
        end
        if (item_op == flsa_pkg::OPC_FREE) begin
          if (take_free) begin
            found <= 1'b1;
            pick  <= (pend_ptr == '0 && rd_start == blk) ? CW'(1) : CW'(pend_ptr);
          end
        end else if (take_alloc) begin
          found      <= 1'b1;
          pick       <= CW'(pend_ptr);
          pick_start <= rd_start;
          pick_size  <= rd_size;
        end
      end
      flsa_pkg::OP_GRANT: begin
        res_addr <= 32'(grant_addr);
        res_size <= pick_size;
      end
      flsa_pkg::OP_BRK: begin
        if (oom) begin
          res_status <= flsa_pkg::ST_OOM;
        end else begin
          res_addr <= 32'(brk_hdr);
          res_size <= need[SW-1:0];
        end
      end
      flsa_pkg::OP_SHDN_INIT: ptr <= pick_p1;
      flsa_pkg::OP_SHDN: begin
        if (shdn_issue) begin
          ptr <= ptr + CW'(1);
        end
      end
      flsa_pkg::OP_SHUP_INIT: begin
        if (!found) begin
          pick <= count;
        end
        ptr <= count;
      end
      flsa_pkg::OP_SHUP: begin
        if (shup_issue) begin
          ptr <= ptr_m1;
        end
      end
      flsa_pkg::OP_MRG_RD0: base_i <= '0;
      flsa_pkg::OP_MRG_CUR: begin
        cur_start <= rd_start;
        cur_size  <= rd_size;
      end
      flsa_pkg::OP_MRG_CMP: begin
        if (merge_hit) begin
          cur_size <= merged;
          pick     <= base_p1;
        end else begin
          base_i    <= base_p1;
          cur_start <= rd_start;
          cur_size  <= rd_size;
        end
      end
      default: begin
      end
    endcase
    if (cmd.publish) begin
      result_addr  <= res_addr;
      granted_size <= res_size;
      status       <= res_status;
    end
  end

  assign sts.is_alloc   = (item_op == flsa_pkg::OPC_ALLOC);
  assign sts.is_free    = (item_op == flsa_pkg::OPC_FREE);
  assign sts.is_clear   = (item_op == flsa_pkg::OPC_CLEAR);
  assign sts.reject     = (res_status != flsa_pkg::ST_OK);
  assign sts.align_done = (bit_cnt == BW'(DW / 4));
  assign sts.scan_done  = !pend && !scan_issue;
  assign sts.found      = found;
  assign sts.shdn_done  = !pend && !shdn_issue;
  assign sts.shup_done  = !pend && !shup_issue;
  assign sts.merge_more = (base_p1_x < (CW+1)'(count));
  assign sts.merge_hit  = merge_hit;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FREE_SLOTS))
    else $error("free table count past capacity");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == flsa_pkg::OP_INSERT) |-> (count < CW'(FREE_SLOTS)))
    else $error("insert into a full free table");
  a_grant_found: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == flsa_pkg::OP_GRANT) |-> found)
    else $error("grant without a fitting segment");
`endif

endmodule

FILE: hw/rtl/flsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_ctrl
// sequencer for allocate, free and clear requests, output beat control
// ----------------------------------------------------------------------------
module flsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  flsa_pkg::dp_status_t sts,
  output flsa_pkg::dp_cmd_t    cmd
);

  flsa_pkg::ctrl_state_t state, state_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= flsa_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = flsa_pkg::OP_NONE;
    cmd.publish = 1'b0;
    in_ready    = (state == flsa_pkg::S_IDLE);
    unique case (state)
      flsa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = flsa_pkg::OP_LOAD;
          state_next = flsa_pkg::S_DISPATCH;
        end
      end
      flsa_pkg::S_DISPATCH: begin
        if (sts.is_alloc) begin
          state_next = flsa_pkg::S_ALIGN;
        end else if (sts.is_free) begin
          state_next = sts.reject ? flsa_pkg::S_DONE : flsa_pkg::S_SCAN_INIT;
        end else begin
          if (sts.is_clear) begin
            cmd.op = flsa_pkg::OP_CLEAR;
          end
          state_next = flsa_pkg::S_DONE;
        end
      end
      flsa_pkg::S_ALIGN: begin
        if (sts.align_done) begin
          state_next = flsa_pkg::S_SCAN_INIT;
        end else begin
          cmd.op = flsa_pkg::OP_ALIGN;
        end
      end
      flsa_pkg::S_SCAN_INIT: begin
        cmd.op     = flsa_pkg::OP_SCAN_INIT;
        state_next = flsa_pkg::S_SCAN;
      end
      flsa_pkg::S_SCAN: begin
        cmd.op = flsa_pkg::OP_SCAN;
        if (sts.scan_done) begin
          state_next = sts.is_alloc ? flsa_pkg::S_DECIDE : flsa_pkg::S_SHUP_INIT;
        end
      end
      flsa_pkg::S_DECIDE: begin
        if (sts.found) begin
          cmd.op     = flsa_pkg::OP_GRANT;
          state_next = flsa_pkg::S_SHDN_INIT;
        end else begin
          state_next = flsa_pkg::S_BRK;
        end
      end
      flsa_pkg::S_BRK: begin
        cmd.op     = flsa_pkg::OP_BRK;
        state_next = flsa_pkg::S_DONE;
      end
      flsa_pkg::S_SHDN_INIT: begin
        cmd.op     = flsa_pkg::OP_SHDN_INIT;
        state_next = flsa_pkg::S_SHDN;
      end
      flsa_pkg::S_SHDN: begin
        cmd.op = flsa_pkg::OP_SHDN;
        if (sts.shdn_done) begin
          state_next = sts.is_free ? flsa_pkg::S_MRG_NEXT : flsa_pkg::S_DONE;
        end
      end
      flsa_pkg::S_SHUP_INIT: begin
        cmd.op     = flsa_pkg::OP_SHUP_INIT;
        state_next = flsa_pkg::S_SHUP;
      end
      flsa_pkg::S_SHUP: begin
        cmd.op = flsa_pkg::OP_SHUP;
        if (sts.shup_done) begin
          state_next = flsa_pkg::S_INSERT;
        end
      end
      flsa_pkg::S_INSERT: begin
        cmd.op     = flsa_pkg::OP_INSERT;
        state_next = flsa_pkg::S_MRG_RD0;
      end
      flsa_pkg::S_MRG_RD0: begin
        cmd.op     = flsa_pkg::OP_MRG_RD0;
        state_next = flsa_pkg::S_MRG_CUR;
      end
      flsa_pkg::S_MRG_CUR: begin
        cmd.op     = flsa_pkg::OP_MRG_CUR;
        state_next = flsa_pkg::S_MRG_NEXT;
      end
      flsa_pkg::S_MRG_NEXT: begin
        if (sts.merge_more) begin
          cmd.op     = flsa_pkg::OP_MRG_RDJ;
          state_next = flsa_pkg::S_MRG_CMP;
        end else begin
          state_next = flsa_pkg::S_DONE;
        end
      end
      flsa_pkg::S_MRG_CMP: begin
        cmd.op     = flsa_pkg::OP_MRG_CMP;
        state_next = sts.merge_hit ? flsa_pkg::S_SHDN_INIT : flsa_pkg::S_MRG_NEXT;
      end
      flsa_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = flsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = flsa_pkg::S_IDLE;
      end
    endcase
    out_valid_next = cmd.publish || (out_valid && !out_ready);
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == flsa_pkg::S_DISPATCH))
    else $error("accepted request not dispatched");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == flsa_pkg::S_DONE && out_valid && !out_ready) |=>
    (state == flsa_pkg::S_DONE && out_valid))
    else $error("finished result overran a stalled output beat");
`endif

endmodule

FILE: hw/rtl/free_list_segment_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_segment_allocator
// heap allocator over an address-sorted table of free segments
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one result beat.
// In an allocate, an align unit rounds the size up four bits a cycle, the scan
// reads one entry per cycle through the single read port of the table memory
// (first fit stops early), and the chosen entry k is removed by moving the
// entries above it down one a cycle. A free runs a position scan up to the
// insert point p, a shift up from p, then a merge walk that compares each
// neighbor pair and closes each hit with a shift down. Null frees, frees into
// a full table and clears skip the scan and go straight to the result. The
// finished result sits in an output register, so the block is idle for the
// next request while a result beat waits for out_ready.
module free_list_segment_allocator #(
  parameter int FREE_SLOTS   = 64,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 16,
  parameter int ADDR_BITS    = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [flsa_pkg::SIZE_W-1:0]    req_size,
  input  logic [flsa_pkg::SIZE_W-1:0]    payload_addr,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [flsa_pkg::SIZE_W-1:0]    result_addr,
  output logic [flsa_pkg::SIZE_W-1:0]    granted_size,
  output logic [1:0]                     status,
  // configuration writes: fit mode, heap base (also reloads break), limit
  input  logic                           cfg_wr_en,
  input  logic [flsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [flsa_pkg::SIZE_W-1:0]    cfg_wdata
);

  // command and status between sequencer and datapath
  flsa_pkg::dp_cmd_t    cmd;
  flsa_pkg::dp_status_t sts;

  flsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table memories, align unit, break pointer and result registers
  flsa_dp #(
    .FREE_SLOTS   (FREE_SLOTS),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .opcode       (opcode),
    .req_size     (req_size),
    .payload_addr (payload_addr),
    .result_addr  (result_addr),
    .granted_size (granted_size),
    .status       (status)
  );

endmodule
